@@ hdl/stepper_door_move_controller_unit_macros.svh @@
// Assertion macros for the stepper door move controller.
// Needs a clock named clk and a synchronous reset named rst in the module that uses them.
`ifndef STEPPER_DOOR_MOVE_CONTROLLER_UNIT_MACROS_SVH
`define STEPPER_DOOR_MOVE_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SDMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdmc check failed");
// The consequent must hold in the cycle after the antecedent.
`define SDMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdmc check failed");
`else
`define SDMC_ASSERT_NOW(label, ante, cons)
`define SDMC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hdl/sdmc_pkg.sv @@
// Package for the stepper door move controller: codes, types and the half-step coil table.
// Depends on nothing.
`default_nettype none

package sdmc_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned EncW = 16;
  localparam int unsigned IntervalW = 12;
  localparam int unsigned PhaseW = 3;

  localparam logic [IntervalW-1:0] INTERVAL_RESET = 12'd300;

  localparam logic [FuncW-1:0] FUNC_TICK = 3'd0;
  localparam logic [FuncW-1:0] FUNC_OPEN = 3'd1;
  localparam logic [FuncW-1:0] FUNC_CLOSE = 3'd2;
  localparam logic [FuncW-1:0] FUNC_STOP = 3'd3;
  localparam logic [FuncW-1:0] FUNC_CAL = 3'd4;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_LIMIT = 2'd1;
  localparam logic [1:0] EV_STOPPED = 2'd2;
  localparam logic [1:0] EV_CAL_DONE = 2'd3;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_OPEN = 3'd1,
    MODE_CLOSE = 3'd2,
    MODE_CAL_UP = 3'd3,
    MODE_CAL_DOWN = 3'd4
  } mode_t;

  // Standard eight-entry half-step sequence, bit 0 drives coil 1.
  function automatic logic [3:0] coil_lookup(input logic [PhaseW-1:0] phase);
    logic [3:0] pattern;
    case (phase)
      3'd0: pattern = 4'd1;
      3'd1: pattern = 4'd3;
      3'd2: pattern = 4'd2;
      3'd3: pattern = 4'd6;
      3'd4: pattern = 4'd4;
      3'd5: pattern = 4'd12;
      3'd6: pattern = 4'd8;
      default: pattern = 4'd9;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

@@ hdl/stepper_door_move_controller_unit.sv @@
// Stepper door move controller: input register, one pass of move logic, result register.
// Depends on sdmc_pkg and stepper_door_move_controller_unit_macros.svh.
//
// Channel   | Direction | Handshake            | Beat contents
// ----------+-----------+----------------------+-------------------------------------------
// command   | in        | cmd_valid/cmd_stall  | func, upper_limit, lower_limit, encoder_count
// result    | out       | res_valid/res_stall  | coils, moving, led_on, event_res,
//           |           |                      | stall_detected, travel_steps, encoder_span
// interval  | in        | interval_we          | interval_wdata (steps between stall checks)
//
// One command beat is taken every cycle while cmd_stall is low; each beat gives exactly one
// result beat, passing through the input register and then the result register.
// The move state is updated in the cycle in which a beat leaves the input register.
// The synchronous reset empties both registers and restores the power-on move state,
// with a stall check interval of 300 steps.
// A stall on the result side holds the result register; the input register still takes
// a beat while the result register waits and only stalls once both are full.
`default_nettype none

module stepper_door_move_controller_unit
  import sdmc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration.
  input  wire logic                 interval_we,
  input  wire logic [IntervalW-1:0] interval_wdata,
  // Command channel.
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire logic [FuncW-1:0]     func,
  input  wire logic                 upper_limit,
  input  wire logic                 lower_limit,
  input  wire logic [EncW-1:0]      encoder_count,
  // Result channel.
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic [3:0]                coils,
  output logic                      moving,
  output logic                      led_on,
  output logic [1:0]                event_res,
  output logic                      stall_detected,
  output logic [EncW-1:0]           travel_steps,
  output logic [EncW-1:0]           encoder_span
);

  `include "stepper_door_move_controller_unit_macros.svh"

  // Input register.
  logic                 s1_valid;
  logic [FuncW-1:0]     s1_func;
  logic                 s1_upper;
  logic                 s1_lower;
  logic [EncW-1:0]      s1_enc;

  // Move state.
  logic [IntervalW-1:0] interval;
  logic [PhaseW-1:0]    phase_index, phase_index_next;
  logic [1:0]           move_direction, move_direction_next;
  logic                 stop_request, stop_request_next;
  mode_t                mode, mode_next;
  logic [IntervalW-1:0] interval_count, interval_count_next;
  logic [EncW-1:0]      last_progress, last_progress_next;
  logic [EncW-1:0]      encoder_base, encoder_base_next;
  logic [EncW-1:0]      calib_count, calib_count_next;
  logic [EncW-1:0]      span_latch, span_latch_next;

  // Per-beat results.
  logic [3:0]           coils_next;
  logic [1:0]           event_next;
  logic                 stall_next;

  // Helpers.
  logic                 out_free;
  logic                 s1_adv;
  logic                 cmd_take;
  logic [EncW-1:0]      rel;
  logic [PhaseW-1:0]    step_phase;
  logic [IntervalW-1:0] count_inc;

  // The result register can take a beat when it is empty or its beat leaves now.
  assign out_free  = !res_valid || !res_stall;
  assign s1_adv    = s1_valid && out_free;
  assign cmd_stall = s1_valid && !out_free;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_func  <= func;
      s1_upper <= upper_limit;
      s1_lower <= lower_limit;
      s1_enc   <= encoder_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (interval_we) begin
      interval <= interval_wdata;
    end
  end

  // Encoder progress is measured from the count captured at the start of the move.
  assign rel       = s1_enc - encoder_base;
  assign count_inc = interval_count + IntervalW'(1);

  // Up turns the phase backwards through the table and down turns it forwards.
  always_comb begin
    case (move_direction)
      DIR_UP:   step_phase = phase_index - PhaseW'(1);
      DIR_DOWN: step_phase = phase_index + PhaseW'(1);
      default:  step_phase = phase_index;
    endcase
  end

  always_comb begin
    phase_index_next    = phase_index;
    move_direction_next = move_direction;
    stop_request_next   = stop_request;
    mode_next           = mode;
    interval_count_next = interval_count;
    last_progress_next  = last_progress;
    encoder_base_next   = encoder_base;
    calib_count_next    = calib_count;
    span_latch_next     = span_latch;
    coils_next          = 4'd0;
    event_next          = EV_NONE;
    stall_next          = 1'b0;

    unique case (s1_func) inside
      FUNC_OPEN, FUNC_CLOSE: begin
        // A start command restarts the move from scratch, even during another move.
        mode_next           = (s1_func == FUNC_OPEN) ? MODE_OPEN : MODE_CLOSE;
        move_direction_next = (s1_func == FUNC_OPEN) ? DIR_UP : DIR_DOWN;
        encoder_base_next   = s1_enc;
        last_progress_next  = '0;
        interval_count_next = '0;
      end
      FUNC_STOP: begin
        stop_request_next = !stop_request;
      end
      FUNC_CAL: begin
        mode_next           = MODE_CAL_UP;
        move_direction_next = DIR_UP;
        calib_count_next    = '0;
      end
      FUNC_TICK: begin
        unique case (mode)
          MODE_OPEN, MODE_CLOSE: begin
            // Limit first, then the stop flag, then a step and perhaps a progress check.
            if ((mode == MODE_OPEN) ? s1_upper : s1_lower) begin
              mode_next  = MODE_IDLE;
              event_next = EV_LIMIT;
            end else if (stop_request) begin
              phase_index_next    = '0;
              move_direction_next = DIR_NONE;
              span_latch_next     = rel;
              mode_next           = MODE_IDLE;
              event_next          = EV_STOPPED;
            end else begin
              phase_index_next    = step_phase;
              coils_next          = coil_lookup(step_phase);
              interval_count_next = count_inc;
              if (count_inc == interval) begin
                interval_count_next = '0;
                if (rel > last_progress) begin
                  last_progress_next = rel;
                end else begin
                  stop_request_next = !stop_request;
                  stall_next        = 1'b1;
                end
              end
            end
          end
          MODE_CAL_UP: begin
            // The upper switch only turns the motor round; stepping down starts next tick.
            if (s1_upper) begin
              phase_index_next    = '0;
              move_direction_next = DIR_DOWN;
              encoder_base_next   = s1_enc;
              mode_next           = MODE_CAL_DOWN;
            end else begin
              phase_index_next = step_phase;
              coils_next       = coil_lookup(step_phase);
            end
          end
          MODE_CAL_DOWN: begin
            if (s1_lower) begin
              phase_index_next    = '0;
              move_direction_next = DIR_NONE;
              span_latch_next     = rel;
              mode_next           = MODE_IDLE;
              event_next          = EV_CAL_DONE;
            end else begin
              phase_index_next = step_phase;
              coils_next       = coil_lookup(step_phase);
              if (calib_count != '1) begin
                calib_count_next = calib_count + EncW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index    <= '0;
      move_direction <= DIR_UP;
      stop_request   <= 1'b0;
      mode           <= MODE_IDLE;
      interval_count <= '0;
      last_progress  <= '0;
      encoder_base   <= '0;
      calib_count    <= '0;
      span_latch     <= '0;
    end else if (s1_adv) begin
      phase_index    <= phase_index_next;
      move_direction <= move_direction_next;
      stop_request   <= stop_request_next;
      mode           <= mode_next;
      interval_count <= interval_count_next;
      last_progress  <= last_progress_next;
      encoder_base   <= encoder_base_next;
      calib_count    <= calib_count_next;
      span_latch     <= span_latch_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      coils          <= coils_next;
      moving         <= (mode_next != MODE_IDLE);
      led_on         <= (mode_next == MODE_OPEN) || (mode_next == MODE_CLOSE);
      event_res      <= event_next;
      stall_detected <= stall_next;
      travel_steps   <= calib_count_next;
      encoder_span   <= span_latch_next;
    end
  end

  // The lamp only burns during a move.
  `SDMC_ASSERT_NOW(a_led_implies_moving, res_valid && led_on, moving)
  // A stall is only found on a step of an open or close move that keeps running.
  `SDMC_ASSERT_NOW(a_stall_in_move, res_valid && stall_detected, led_on && (coils != 4'd0))
  // A beat that ends a move takes no step.
  `SDMC_ASSERT_NOW(a_event_no_step, res_valid && (event_res != EV_NONE), coils == 4'd0)
  // A stopped motor always rests on the first phase.
  `SDMC_ASSERT_NEXT(a_stopped_phase, s1_adv, (move_direction != DIR_NONE) || (phase_index == '0))

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stepper door move controller unit.
// Needs sdmc_pkg and the controller RTL; results are predicted in the bench itself.

module tb_top
  import sdmc_pkg::*;
;

  // Unused function codes, which the controller must ignore.
  localparam logic [FuncW-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FuncW-1:0] FUNC_SPARE_HI = 3'd7;

  // Half-step coil patterns, entry n in bits 4n+3 down to 4n.
  localparam logic [31:0] HALF_STEP_TABLE = {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

  // The slowest correct run needs far fewer cycles than this, so the limit is ample.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result beat, field for field as the controller presents it.
  typedef struct packed {
    logic [3:0]      coils;
    logic            moving;
    logic            led_on;
    logic [1:0]      ev;
    logic            stall;
    logic [EncW-1:0] steps;
    logic [EncW-1:0] span;
  } door_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 interval_we = 1'b0;
  logic [IntervalW-1:0] interval_wdata = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  logic [FuncW-1:0]     func = FUNC_TICK;
  logic                 upper_limit = 1'b0;
  logic                 lower_limit = 1'b0;
  logic [EncW-1:0]      encoder_count = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [3:0]           coils;
  logic                 moving;
  logic                 led_on;
  logic [1:0]           event_res;
  logic                 stall_detected;
  logic [EncW-1:0]      travel_steps;
  logic [EncW-1:0]      encoder_span;

  stepper_door_move_controller_unit uut (
    .clk            (clk),
    .rst            (rst),
    .interval_we    (interval_we),
    .interval_wdata (interval_wdata),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .func           (func),
    .upper_limit    (upper_limit),
    .lower_limit    (lower_limit),
    .encoder_count  (encoder_count),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .coils          (coils),
    .moving         (moving),
    .led_on         (led_on),
    .event_res      (event_res),
    .stall_detected (stall_detected),
    .travel_steps   (travel_steps),
    .encoder_span   (encoder_span)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted door state. It is advanced once for every command beat that the
  // controller accepts, in the order of acceptance.
  // ---------------------------------------------------------------------------
  logic [PhaseW-1:0]    door_phase;
  logic [1:0]           door_dir;
  logic                 door_stop_flag;
  mode_t                door_mode;
  logic [IntervalW-1:0] door_interval_steps;
  logic [IntervalW-1:0] door_interval;
  logic [EncW-1:0]      door_progress;
  logic [EncW-1:0]      door_origin;
  logic [EncW-1:0]      door_cal_steps;
  logic [EncW-1:0]      door_span;

  // Results predicted for accepted command beats, oldest first.
  door_result_t pending_results[$];

  int unsigned errors = 0;
  int unsigned result_no = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  logic [EncW-1:0] enc_now = '0;
  door_result_t seen;
  door_result_t want;

  task automatic door_reset();
    door_phase = '0;
    door_dir = DIR_UP;
    door_stop_flag = 1'b0;
    door_mode = MODE_IDLE;
    door_interval_steps = '0;
    door_interval = INTERVAL_RESET;
    door_progress = '0;
    door_origin = '0;
    door_cal_steps = '0;
    door_span = '0;
  endtask

  // One motor step in the present direction; returns the pattern now driven.
  function automatic logic [3:0] door_take_step();
    if (door_dir == DIR_UP) begin
      door_phase = door_phase - 3'd1;
    end else if (door_dir == DIR_DOWN) begin
      door_phase = door_phase + 3'd1;
    end
    return HALF_STEP_TABLE[{door_phase, 2'b00} +: 4];
  endfunction

  function automatic door_result_t door_next_result(input logic [FuncW-1:0] f, input logic up,
                                                     input logic lo, input logic [EncW-1:0] enc);
    door_result_t r;
    logic [EncW-1:0] rel;
    logic hit;
    r = '0;
    rel = enc - door_origin;
    hit = 1'b0;
    case (f)
      FUNC_OPEN, FUNC_CLOSE: begin
        // A start always begins afresh, even in the middle of another move.
        door_mode = (f == FUNC_OPEN) ? MODE_OPEN : MODE_CLOSE;
        door_dir = (f == FUNC_OPEN) ? DIR_UP : DIR_DOWN;
        door_origin = enc;
        door_progress = '0;
        door_interval_steps = '0;
      end
      FUNC_STOP: begin
        door_stop_flag = ~door_stop_flag;
      end
      FUNC_CAL: begin
        door_mode = MODE_CAL_UP;
        door_dir = DIR_UP;
        door_cal_steps = '0;
      end
      FUNC_TICK: begin
        if (door_mode == MODE_OPEN || door_mode == MODE_CLOSE) begin
          hit = (door_mode == MODE_OPEN) ? up : lo;
          if (hit) begin
            // Reaching the switch leaves the phase and the direction alone.
            door_mode = MODE_IDLE;
            r.ev = EV_LIMIT;
          end else if (door_stop_flag) begin
            door_phase = '0;
            door_dir = DIR_NONE;
            door_span = rel;
            door_mode = MODE_IDLE;
            r.ev = EV_STOPPED;
          end else begin
            r.coils = door_take_step();
            door_interval_steps = door_interval_steps + 12'd1;
            if (door_interval_steps == door_interval) begin
              door_interval_steps = '0;
              if (rel > door_progress) begin
                door_progress = rel;
              end else begin
                door_stop_flag = ~door_stop_flag;
                r.stall = 1'b1;
              end
            end
          end
        end else if (door_mode == MODE_CAL_UP) begin
          if (up) begin
            // The switch tick only turns the motor round; stepping down starts next tick.
            door_phase = '0;
            door_dir = DIR_DOWN;
            door_origin = enc;
            door_mode = MODE_CAL_DOWN;
          end else begin
            r.coils = door_take_step();
          end
        end else if (door_mode == MODE_CAL_DOWN) begin
          if (lo) begin
            door_phase = '0;
            door_dir = DIR_NONE;
            door_span = rel;
            door_mode = MODE_IDLE;
            r.ev = EV_CAL_DONE;
          end else begin
            r.coils = door_take_step();
            if (door_cal_steps != 16'hFFFF) begin
              door_cal_steps = door_cal_steps + 16'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.moving = (door_mode != MODE_IDLE);
    r.led_on = (door_mode == MODE_OPEN || door_mode == MODE_CLOSE);
    r.steps = door_cal_steps;
    r.span = door_span;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Every mismatch prints one line and is counted.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at result %0d: %s", result_no, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_v));
    end
  endtask

  // Every result beat taken from the controller is matched against the oldest
  // prediction. Sampling at the rising edge sees the values of the cycle just ended.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      seen = {coils, moving, led_on, event_res, stall_detected, travel_steps, encoder_span};
      if (pending_results.size() == 0) begin
        report_mismatch("result beat arrived with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("coils", 32'(seen.coils), 32'(want.coils));
        check_field("moving", 32'(seen.moving), 32'(want.moving));
        check_field("led_on", 32'(seen.led_on), 32'(want.led_on));
        check_field("event_res", 32'(seen.ev), 32'(want.ev));
        check_field("stall_detected", 32'(seen.stall), 32'(want.stall));
        check_field("travel_steps", 32'(seen.steps), 32'(want.steps));
        check_field("encoder_span", 32'(seen.span), 32'(want.span));
      end
      result_no++;
    end
  end

  // The result side stalls on a pattern of its own: mostly short runs of stall
  // and short free runs, with now and then a long free stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 5))
        0: begin
          res_stall <= 1'b0;
          stall_left <= $urandom_range(20, 120);
        end
        1, 2: begin
          res_stall <= 1'b1;
          stall_left <= $urandom_range(1, 6);
        end
        default: begin
          res_stall <= 1'b0;
          stall_left <= $urandom_range(1, 6);
        end
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Guard against a hang anywhere in the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic coin(input int unsigned odds);
    return $urandom_range(0, odds - 1) == 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving. All calls are made just after a rising edge, and each task leaves
  // the bench just after a rising edge. The valid is never lowered in a step in
  // which it is raised again.
  // ---------------------------------------------------------------------------

  // Present one command beat and hold it until the controller takes it; the
  // prediction is made at the edge of acceptance.
  task automatic send_beat(input logic [FuncW-1:0] f, input logic up, input logic lo,
                           input logic [EncW-1:0] enc);
    cmd_valid <= 1'b1;
    func <= f;
    upper_limit <= up;
    lower_limit <= lo;
    encoder_count <= enc;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    pending_results.push_back(door_next_result(f, up, lo, enc));
  endtask

  // As send_beat, but in bursts of random length separated by random gaps.
  task automatic issue(input logic [FuncW-1:0] f, input logic up, input logic lo,
                       input logic [EncW-1:0] enc);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = coin(4) ? 0 : $urandom_range(1, 12);
      burst_left = coin(8) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_beat(f, up, lo, enc);
  endtask

  // Hold off the sender until every predicted result has come back, then let
  // the two pipeline registers settle.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // The interval register is only written while the controller is empty.
  task automatic program_interval(input logic [IntervalW-1:0] value);
    drain();
    interval_wdata <= value;
    interval_we <= 1'b1;
    @(posedge clk);
    interval_we <= 1'b0;
    door_interval = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked beats: ignored items, a stall with its stop, the sticky stop
  // flag, limits, a restart in mid-move and calibration.
  task automatic test_directed();
    // Idle ticks and spare codes change nothing; the first beats run at the reset interval.
    send_beat(FUNC_TICK, 1'b1, 1'b1, 16'hFFFF);
    send_beat(FUNC_SPARE_LO, 1'b0, 1'b1, 16'h0000);
    send_beat(FUNC_SPARE_HI, 1'b1, 1'b0, 16'h5A5A);
    program_interval(12'd1);
    // Open from the top of the encoder range; the count wraps to zero and then stalls.
    send_beat(FUNC_OPEN, 1'b0, 1'b0, 16'hFFFF);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 16'h0000);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 16'h0000);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 16'h0000);
    // The stop flag is still set, so the next move stops on its first tick.
    send_beat(FUNC_CLOSE, 1'b1, 1'b0, 16'h8000);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 16'h8001);
    // Clear the flag, step once, then meet the lower switch.
    send_beat(FUNC_STOP, 1'b0, 1'b0, 16'h8001);
    send_beat(FUNC_CLOSE, 1'b0, 1'b0, 16'h8000);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 16'h8003);
    send_beat(FUNC_TICK, 1'b1, 1'b1, 16'h8003);
    // A second start in the middle of a move restarts it.
    send_beat(FUNC_OPEN, 1'b0, 1'b0, 16'h0000);
    send_beat(FUNC_TICK, 1'b0, 1'b1, 16'h0005);
    send_beat(FUNC_OPEN, 1'b0, 1'b0, 16'h000A);
    send_beat(FUNC_TICK, 1'b1, 1'b0, 16'h000A);
    // Calibration: one step up, the upper switch, two steps down, the lower switch.
    send_beat(FUNC_CAL, 1'b0, 1'b0, 16'h1234);
    send_beat(FUNC_TICK, 1'b0, 1'b1, 16'h1238);
    send_beat(FUNC_TICK, 1'b1, 1'b0, 16'h1240);
    send_beat(FUNC_TICK, 1'b0, 1'b0, 16'h1250);
    send_beat(FUNC_TICK, 1'b1, 1'b0, 16'h1260);
    send_beat(FUNC_TICK, 1'b0, 1'b1, 16'h1270);
    // Calibration requested while an open move runs.
    send_beat(FUNC_OPEN, 1'b0, 1'b0, 16'h2000);
    send_beat(FUNC_CAL, 1'b0, 1'b0, 16'h2001);
    send_beat(FUNC_TICK, 1'b1, 1'b1, 16'h2002);
    send_beat(FUNC_TICK, 1'b0, 1'b1, 16'h2003);
  endtask

  // Well-formed open and close moves with random content. The encoder mostly
  // advances, but some moves hold it still so that the progress check trips.
  task automatic test_door_moves(input logic [IntervalW-1:0] interval, input int unsigned beats);
    int unsigned sent;
    int unsigned ticks;
    int unsigned t;
    logic opening;
    logic stuck;
    program_interval(interval);
    sent = 0;
    while (sent < beats) begin
      // A stop flag left set would end every move at once, so mostly clear it first.
      if (door_stop_flag && !coin(5)) begin
        issue(FUNC_STOP, coin(2), coin(2), enc_now);
        sent++;
      end
      opening = coin(2);
      stuck = coin(6);
      enc_now = 16'($urandom);
      issue(opening ? FUNC_OPEN : FUNC_CLOSE, coin(2), coin(2), enc_now);
      ticks = $urandom_range(0, 40);
      for (t = 0; t < ticks; t++) begin
        if (!stuck) begin
          enc_now = enc_now + 16'($urandom_range(0, 3));
        end
        if (coin(30)) begin
          issue(FUNC_STOP, coin(2), coin(2), enc_now);
        end else if (opening) begin
          issue(FUNC_TICK, 1'b0, coin(2), enc_now);
        end else begin
          issue(FUNC_TICK, coin(2), 1'b0, enc_now);
        end
      end
      issue(FUNC_TICK, opening ? 1'b1 : coin(2), opening ? coin(2) : 1'b1, enc_now);
      sent += ticks + 2;
    end
  endtask

  // Calibration runs of random length; some are cut short by a start command,
  // and stop toggles along the way must be ignored.
  task automatic test_calibration(input int unsigned beats);
    int unsigned sent;
    int unsigned n;
    int unsigned t;
    program_interval(12'($urandom_range(1, 30)));
    sent = 0;
    while (sent < beats) begin
      enc_now = 16'($urandom);
      issue(FUNC_CAL, coin(2), coin(2), enc_now);
      n = $urandom_range(0, 20);
      for (t = 0; t < n; t++) begin
        enc_now = enc_now + 16'($urandom_range(0, 3));
        issue(coin(25) ? FUNC_STOP : FUNC_TICK, 1'b0, coin(2), enc_now);
      end
      sent += n + 1;
      if (coin(8)) begin
        issue(FUNC_OPEN, coin(2), coin(2), enc_now);
        sent++;
      end else begin
        issue(FUNC_TICK, 1'b1, coin(2), enc_now);
        n = $urandom_range(0, 30);
        for (t = 0; t < n; t++) begin
          enc_now = enc_now - 16'($urandom_range(0, 3));
          issue(coin(25) ? FUNC_STOP : FUNC_TICK, coin(2), 1'b0, enc_now);
        end
        issue(FUNC_TICK, coin(2), 1'b1, enc_now);
        sent += n + 2;
      end
    end
  endtask

  // One long downward calibration run sent back to back; the result side still
  // stalls as usual.
  task automatic test_long_descent();
    int unsigned t;
    drain();
    enc_now = 16'($urandom);
    send_beat(FUNC_CAL, 1'b0, 1'b0, enc_now);
    send_beat(FUNC_TICK, 1'b0, 1'b0, enc_now);
    send_beat(FUNC_TICK, 1'b1, 1'b0, enc_now);
    for (t = 0; t < 60; t++) begin
      enc_now = enc_now + 16'd1;
      send_beat(FUNC_TICK, 1'b0, 1'b0, enc_now);
    end
    send_beat(FUNC_TICK, 1'b0, 1'b1, enc_now);
  endtask

  // Unstructured beats: any code, any switch levels, jumps in the encoder.
  task automatic test_noise(input int unsigned beats);
    int unsigned i;
    logic [FuncW-1:0] f;
    program_interval(12'($urandom_range(1, 6)));
    for (i = 0; i < beats; i++) begin
      f = coin(2) ? FUNC_TICK : 3'($urandom_range(1, 7));
      enc_now = coin(3) ? 16'($urandom) : enc_now + 16'($urandom_range(0, 2));
      issue(f, coin(5), coin(5), enc_now);
    end
  endtask

  initial begin
    door_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    // Door moves over several intervals, the widest and the wrapping zero among them.
    test_door_moves(12'd3, 150);
    test_door_moves(12'd1, 100);
    test_door_moves(12'd4095, 100);
    test_door_moves(12'd0, 60);
    test_door_moves(12'($urandom_range(2, 16)), 150);
    test_calibration(150);
    test_long_descent();
    test_noise(150);
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sdmc_pkg.sv
hdl/stepper_door_move_controller_unit.sv
tb/tb_top.sv
